// ===== sv/tbn_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle tangent and binormal package
// Shared constants, state encoding and the command and status groups that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tbn_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] THR_RESET = 32'd4295;
  localparam logic [1:0] REG_THR = 2'd0;

  localparam int CRD_W = 32;
  localparam int DLT_W = CRD_W + 1;
  localparam int PRD_W = 2 * DLT_W;
  localparam int VAL_W = PRD_W + 1;
  localparam int MAG_W = PRD_W;
  localparam int QUO_W = 32;
  localparam int DIV_W = MAG_W + QUO_W - 1;

  localparam logic [2:0] TERM_DET  = 3'd0;
  localparam logic [2:0] TERM_TX   = 3'd1;
  localparam logic [2:0] TERM_TY   = 3'd2;
  localparam logic [2:0] TERM_TZ   = 3'd3;
  localparam logic [2:0] TERM_BX   = 3'd4;
  localparam logic [2:0] TERM_BY   = 3'd5;
  localparam logic [2:0] TERM_LAST = 3'd6;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL0   = 9'b000000010,
    S_MUL1   = 9'b000000100,
    S_SUB    = 9'b000001000,
    S_DETCHK = 9'b000010000,
    S_DINIT  = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_STORE  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic       store_corner;
    logic       corner_sel;
    logic       load_delta;
    logic       mul_en;
    logic       mul_second;
    logic [2:0] term;
    logic       sub_en;
    logic       det_en;
    logic       div_init;
    logic       div_step;
    logic       res_store;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// ===== sv/tbn_datapath.sv =====
// ----------------------------------------------------------------------------
// Triangle tangent and binormal datapath
// Corner store, deltas, a shared multiplier, determinant check, a radix-2
// restoring divider, result staging, output register and the register port.
// ----------------------------------------------------------------------------
module tbn_datapath import tbn_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic [159:0]  in_data,
  output logic [191:0]  out_data,
  output logic          out_user,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata
);

  logic [31:0]              det_threshold;
  logic signed [CRD_W-1:0]  cp [2][5];
  logic signed [DLT_W-1:0]  e1 [3];
  logic signed [DLT_W-1:0]  e2 [3];
  logic signed [DLT_W-1:0]  du1, dv1, du2, dv2;
  logic signed [DLT_W-1:0]  op_a, op_b;
  logic signed [PRD_W-1:0]  prod, first;
  logic signed [VAL_W-1:0]  val;
  logic [MAG_W-1:0]         val_mag, dreg;
  logic                     det_neg, repl, repl_now, q_neg;
  logic [DIV_W-1:0]         rem, dsh;
  logic [DIV_W:0]           diff;
  logic [QUO_W-1:0]         q;
  logic [31:0]              sat_val;
  logic [31:0]              res [6];
  logic [VAL_W-1:0]         val_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && (paddr == REG_THR)) begin
      det_threshold <= pwdata;
    end
  end
  assign prdata = det_threshold;

  always_ff @(posedge clk) begin
    if (cmd.store_corner) begin
      for (int k = 0; k < 5; k++) begin
        cp[cmd.corner_sel][k] <= in_data[32*k +: 32];
      end
    end
    if (cmd.load_delta) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= DLT_W'(cp[1][k]) - DLT_W'(cp[0][k]);
        e2[k] <= DLT_W'($signed(in_data[32*k +: 32])) - DLT_W'(cp[0][k]);
      end
      du1 <= DLT_W'(cp[1][3]) - DLT_W'(cp[0][3]);
      dv1 <= DLT_W'(cp[1][4]) - DLT_W'(cp[0][4]);
      du2 <= DLT_W'($signed(in_data[127:96])) - DLT_W'(cp[0][3]);
      dv2 <= DLT_W'($signed(in_data[159:128])) - DLT_W'(cp[0][4]);
    end
  end

  always_comb begin
    op_a = du1;
    op_b = dv2;
    case (cmd.term)
      TERM_DET: begin
        op_a = cmd.mul_second ? dv1 : du1;
        op_b = cmd.mul_second ? du2 : dv2;
      end
      TERM_TX: begin
        op_a = cmd.mul_second ? dv1 : dv2;
        op_b = cmd.mul_second ? e2[0] : e1[0];
      end
      TERM_TY: begin
        op_a = cmd.mul_second ? dv1 : dv2;
        op_b = cmd.mul_second ? e2[1] : e1[1];
      end
      TERM_TZ: begin
        op_a = cmd.mul_second ? dv1 : dv2;
        op_b = cmd.mul_second ? e2[2] : e1[2];
      end
      TERM_BX: begin
        op_a = cmd.mul_second ? du2 : du1;
        op_b = cmd.mul_second ? e1[0] : e2[0];
      end
      TERM_BY: begin
        op_a = cmd.mul_second ? du2 : du1;
        op_b = cmd.mul_second ? e1[1] : e2[1];
      end
      default: begin
        op_a = cmd.mul_second ? du2 : du1;
        op_b = cmd.mul_second ? e1[2] : e2[2];
      end
    endcase
  end

  assign val_neg  = -val;
  assign val_mag  = val[VAL_W-1] ? val_neg[MAG_W-1:0] : val[MAG_W-1:0];
  assign repl_now = (val_mag < {{(MAG_W-32){1'b0}}, det_threshold}) || (val_mag == '0);
  assign diff     = {1'b0, rem} - {1'b0, dsh};

  always_comb begin
    if (q[QUO_W-1]) begin
      sat_val = q_neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat_val = q_neg ? (~q + 32'd1) : q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
      if (cmd.mul_second) begin
        first <= prod;
      end
    end
    if (cmd.sub_en) begin
      val <= VAL_W'(first) - VAL_W'(prod);
    end
    if (cmd.det_en) begin
      repl    <= repl_now;
      det_neg <= !repl_now && val[VAL_W-1];
      dreg    <= repl_now ? (MAG_W'(1) << (2 * FracBits)) : val_mag;
    end
    if (cmd.div_init) begin
      rem   <= DIV_W'(val_mag) << FracBits;
      dsh   <= DIV_W'(dreg) << (QUO_W - 1);
      q     <= '0;
      q_neg <= val[VAL_W-1] ^ det_neg;
    end else if (cmd.div_step) begin
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
      end
      q   <= {q[QUO_W-2:0], !diff[DIV_W]};
      dsh <= dsh >> 1;
    end
    if (cmd.res_store) begin
      res[3'(cmd.term - 3'd1)] <= sat_val;
    end
    if (cmd.out_load) begin
      out_data <= {res[5], res[4], res[3], res[2], res[1], res[0]};
      out_user <= repl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_full = out_valid;

endmodule

// ===== sv/tbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// Triangle tangent and binormal controller
// Counts corners and sequences products, determinant check, divisions and
// result hand-over for each completed triangle.
// ----------------------------------------------------------------------------
module tbn_ctrl import tbn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t      state, state_next;
  logic [1:0]  count, count_next;
  logic [2:0]  term, term_next;
  logic [4:0]  div_cnt, div_cnt_next;
  logic        accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    count_next   = count;
    term_next    = term;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.term     = term;
    cmd.corner_sel = count[0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (count == 2'd2) begin
            cmd.load_delta = 1'b1;
            count_next     = 2'd0;
            term_next      = TERM_DET;
            state_next     = S_MUL0;
          end else begin
            cmd.store_corner = 1'b1;
            count_next       = count + 2'd1;
          end
        end
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_second = 1'b1;
        state_next     = S_SUB;
      end
      S_SUB: begin
        cmd.sub_en = 1'b1;
        state_next = (term == TERM_DET) ? S_DETCHK : S_DINIT;
      end
      S_DETCHK: begin
        cmd.det_en = 1'b1;
        term_next  = TERM_TX;
        state_next = S_MUL0;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 5'd1;
        if (div_cnt == 5'd31) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.res_store = 1'b1;
        if (term == TERM_LAST) begin
          state_next = S_DONE;
        end else begin
          term_next  = term + 3'd1;
          state_next = S_MUL0;
        end
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= 2'd0;
      term    <= TERM_DET;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      term    <= term_next;
      div_cnt <= div_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_third_starts : assert property (@(posedge clk) disable iff (rst)
    accept && count == 2'd2 |=> state == S_MUL0 && term == TERM_DET)
    else $error("third corner did not start a triangle");
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("corner count out of range");
  a_div_len : assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && div_cnt == 5'd31 |=> state == S_STORE)
    else $error("division did not end after 32 steps");
  a_last_term : assert property (@(posedge clk) disable iff (rst)
    state == S_STORE && term == TERM_LAST |=> state == S_DONE)
    else $error("last component did not finish the triangle");
`endif

endmodule

// ===== sv/triangle_tangent_binormal_unit.sv =====
// Corners one and two are accepted while the controller is idle; the third
// corner starts six 32-step divisions and fourteen products through one shared
// multiplier, and no corner is accepted until its result is loaded for output.
// A result waiting at the output does not stop the next triangle's first two
// corners. Reset clears the corner count, the controller, the output valid and
// sets det_threshold to 4295.
// ----------------------------------------------------------------------------
// Triangle tangent and binormal unit
// Per-triangle tangent and binormal in fixed point from streamed vertices.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal_unit import tbn_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // tangent_x/y/z, binormal_x/y/z
  output logic         m_axis_tuser,   // det_replaced
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  tbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tbn_datapath #(.FracBits(FracBits)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

endmodule

// ===== verif/triangle_tangent_binormal_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle tangent and binormal unit testbench
// Streams triangle corners under several determinant thresholds, predicts each
// tangent and binormal in wide integer arithmetic, compares every result with
// the oldest prediction; both streams stall at random but in one pass.
// ----------------------------------------------------------------------------
module triangle_tangent_binormal_unit_tb;
  import tbn_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE = 300;
  localparam logic [1:0] ADDR_THR = 2'd0;

  typedef struct packed {
    logic [31:0] tv, tu, pz, py, px;
  } corner_t;

  typedef struct packed {
    logic        repl;
    logic [31:0] bz, by, bx, tz, ty, tx;
  } frame_t;

  class tbn_scoreboard;
    logic [31:0] thr = THR_RESET;
    int          n_corners = 0;
    corner_t     held[2];
    frame_t      pending[$];
    int          errors = 0;
    int          checked = 0;
    int          replaced = 0;

    function automatic logic signed [127:0] wide(logic [31:0] v);
      return {{96{v[31]}}, v};
    endfunction

    function automatic logic [31:0] ratio(logic signed [127:0] num,
                                           logic signed [127:0] den);
      logic [127:0] n, d, q;
      logic         neg;
      neg = num[127] ^ den[127];
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      q = (n << FB) / d;
      if (neg) begin
        if (q >= 128'h8000_0000) return 32'h8000_0000;
        return -q[31:0];
      end
      if (q > 128'h7fff_ffff) return 32'h7fff_ffff;
      return q[31:0];
    endfunction

    function void note(corner_t c);
      logic signed [127:0] e1 [3], e2 [3], p2 [3];
      logic signed [127:0] du1, dv1, du2, dv2, det, dmag, t, b;
      frame_t f;
      if (n_corners < 2) begin
        held[n_corners] = c;
        n_corners++;
        return;
      end
      n_corners = 0;
      p2[0] = wide(c.px); p2[1] = wide(c.py); p2[2] = wide(c.pz);
      e1[0] = wide(held[1].px) - wide(held[0].px);
      e1[1] = wide(held[1].py) - wide(held[0].py);
      e1[2] = wide(held[1].pz) - wide(held[0].pz);
      e2[0] = p2[0] - wide(held[0].px);
      e2[1] = p2[1] - wide(held[0].py);
      e2[2] = p2[2] - wide(held[0].pz);
      du1 = wide(held[1].tu) - wide(held[0].tu);
      dv1 = wide(held[1].tv) - wide(held[0].tv);
      du2 = wide(c.tu) - wide(held[0].tu);
      dv2 = wide(c.tv) - wide(held[0].tv);
      det = du1 * dv2 - dv1 * du2;
      dmag = det[127] ? -det : det;
      f.repl = (dmag == 0) || (dmag < {96'd0, thr});
      if (f.repl) det = 128'sd1 <<< (2 * FB);
      t = dv2 * e1[0] - dv1 * e2[0]; f.tx = ratio(t, det);
      t = dv2 * e1[1] - dv1 * e2[1]; f.ty = ratio(t, det);
      t = dv2 * e1[2] - dv1 * e2[2]; f.tz = ratio(t, det);
      b = du1 * e2[0] - du2 * e1[0]; f.bx = ratio(b, det);
      b = du1 * e2[1] - du2 * e1[1]; f.by = ratio(b, det);
      b = du1 * e2[2] - du2 * e1[2]; f.bz = ratio(b, det);
      pending = {pending, f};
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(frame_t got);
      frame_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.repl) replaced++;
      cmp("tangent_x", e.tx, got.tx);
      cmp("tangent_y", e.ty, got.ty);
      cmp("tangent_z", e.tz, got.tz);
      cmp("binormal_x", e.bx, got.bx);
      cmp("binormal_y", e.by, got.by);
      cmp("binormal_z", e.bz, got.bz);
      cmp("det_replaced", {31'd0, e.repl}, {31'd0, got.repl});
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;   // pos_x, pos_y, pos_z, tex_u, tex_v
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;        // tangent_x/y/z, binormal_x/y/z
  logic         m_axis_tuser;        // det_replaced
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  tbn_scoreboard sb = new();
  bit            calm = 1'b0;
  int            quiet_cycles = 0;
  int            sent = 0;

  always #5 clk = ~clk;

  triangle_tangent_binormal_unit u_top (.*);

  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check({m_axis_tuser, m_axis_tdata});
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Timed out with %0d results outstanding.", sb.pending.size());
        $display("CHECKS FAILED");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_corner(corner_t c);
    while (!calm && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    do @(posedge clk); while (!s_axis_tready);
    sb.note(c);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_THR; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.thr = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic corner_t mk(logic [31:0] x, y, z, u, v);
    return '{tv: v, tu: u, pz: z, py: y, px: x};
  endfunction

  function automatic logic [31:0] pick(int style);
    case (style)
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic random_triangle();
    int          style, i;
    logic [31:0] bu, bv;
    style = $urandom_range(99);
    bu = $urandom();
    bv = $urandom();
    for (i = 0; i < 3; i++) begin
      if (style < 55)
        send_corner(mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
      else if (style < 75)
        send_corner(mk(pick(2), pick(2), pick(2), pick(2), pick(2)));
      else if (style < 80)
        send_corner(mk(pick(1), pick(1), pick(1), pick(1), pick(1)));
      else if (style < 95)
        send_corner(mk($urandom(), pick(2), $urandom(),
                       bu + $urandom_range(0, 127), bv + $urandom_range(0, 127)));
      else
        send_corner(mk($urandom(), $urandom(), $urandom(), bu, bv));
    end
  endtask

  initial begin
    logic [31:0] thr_plan [6];
    int p, k;
    thr_plan = '{32'd0, 32'hffff_ffff, THR_RESET, 32'd1, 32'd0, 32'd0};
    thr_plan[4] = $urandom_range(0, 1 << 16);
    thr_plan[5] = $urandom();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extremes of every field, a flat UV triangle with zero determinant,
    // a tiny determinant below the reset threshold and a unit-UV triangle.
    send_corner(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_corner(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_corner(mk(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7fff_ffff));
    send_corner(mk(32'h0, 32'h0, 32'h0, 32'h1234, 32'h5678));
    send_corner(mk(32'h10000, 32'h20000, 32'h30000, 32'h1234, 32'h5678));
    send_corner(mk(32'hffff_0000, 32'h40000, 32'h0, 32'h1234, 32'h5678));
    send_corner(mk(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_corner(mk(32'h10000, 32'h0, 32'h0, 32'h10, 32'h0));
    send_corner(mk(32'h0, 32'h10000, 32'h0, 32'h0, 32'h10));
    send_corner(mk(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_corner(mk(32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0));
    send_corner(mk(32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000));
    send_corner(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0));
    send_corner(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h0));
    send_corner(mk(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1));
    drain();

    for (p = 0; p < 6; p++) begin
      write_threshold(thr_plan[p]);
      calm = (p == 2);
      if (p == 0) begin
        // A zero determinant must still be replaced with the threshold at zero.
        send_corner(mk(32'h0, 32'h0, 32'h0, 32'h5, 32'h5));
        send_corner(mk(32'h10000, 32'h0, 32'h0, 32'h5, 32'h5));
        send_corner(mk(32'h0, 32'h10000, 32'h0, 32'h5, 32'h5));
      end
      for (k = 0; k < 61; k++) random_triangle();
      drain();
    end
    calm = 1'b0;

    $display("Sent %0d corners over seven threshold settings; checked %0d results.",
             sent, sb.checked);
    $display("%0d of those results had the determinant replaced.", sb.replaced);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tbn_pkg.sv
sv/tbn_datapath.sv
sv/tbn_ctrl.sv
sv/triangle_tangent_binormal_unit.sv
verif/triangle_tangent_binormal_unit_tb.sv
